// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/atcl_pkg.sv
// Types and constants for the AT command line front end
`timescale 1ns / 1ps
package atcl_pkg;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [15:0] GUARD_RESET = 16'd1000;
	localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

	localparam logic [1:0] MODE_OFFLINE = 2'd0;
	localparam logic [1:0] MODE_ONLINE  = 2'd1;
	localparam logic [1:0] MODE_USER    = 2'd2;

	localparam logic [3:0] CMD_HELP    = 4'd0;
	localparam logic [3:0] CMD_SCAN    = 4'd1;
	localparam logic [3:0] CMD_SSID    = 4'd2;
	localparam logic [3:0] CMD_DIAL    = 4'd3;
	localparam logic [3:0] CMD_ONLINE  = 4'd4;
	localparam logic [3:0] CMD_PETSCII = 4'd5;
	localparam logic [3:0] CMD_ASCII   = 4'd6;
	localparam logic [3:0] CMD_HANGUP  = 4'd7;
	localparam logic [3:0] CMD_UNKNOWN = 4'd8;

	// command words, lower case, first character in the top byte
	function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] i);
		logic [71:0] s;
		case (w)
			3'd0: s = {"athelp", 24'h0};
			3'd1: s = {"atscan", 24'h0};
			3'd2: s = {"atssid", 24'h0};
			3'd3: s = {"atd", 48'h0};
			3'd4: s = {"ato", 48'h0};
			3'd5: s = "atpetscii";
			3'd6: s = {"atascii", 16'h0};
			default: s = {"ath", 48'h0};
		endcase
		word_char = (i < 4'd9) ? s[71 - 8 * int'(i) -: 8] : 8'h00;
	endfunction

	function automatic logic [3:0] word_len(input logic [2:0] w);
		case (w) inside
			[3'd0:3'd2]: word_len = 4'd6;
			[3'd3:3'd4]: word_len = 4'd3;
			3'd5: word_len = 4'd9;
			3'd6: word_len = 4'd7;
			default: word_len = 4'd3;
		endcase
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic [3:0] command_code;
		logic       applied;
		logic [5:0] arg_start;
		logic [5:0] arg_split;
		logic [5:0] line_length;
		logic       petscii_mode;
		logic       last;
	} result_t;
endpackage

// File: sv/at_command_line_with_escape_guard.sv
// Top level: AT modem front end with guard-timed escape and line matcher
`timescale 1ns / 1ps
// One item at a time. A tick or an online byte goes through S_DEC alone. An echoed
// byte also passes S_ECHO (and a CR S_LF), each waiting for a free output register.
// A CR additionally runs the matcher, which reads the line store one character at a time
// through its single port: the command words are tried in turn, then for the ssid and
// dial commands an argument scan runs to the separator or the end of the line.
// The line store is not cleared at reset. Results leave through an output
// register, in_stall stays high while an item is being worked on.
module at_command_line_with_escape_guard #(
	parameter int LINE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        link_accepts,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  out_byte,
	output logic [3:0]  command_code,
	output logic        applied,
	output logic [5:0]  arg_start,
	output logic [5:0]  arg_split,
	output logic [5:0]  line_length,
	output logic        petscii_mode,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import atcl_pkg::*;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DEC   = 10'b0000000010,
		S_ECHO  = 10'b0000000100,
		S_LF    = 10'b0000001000,
		S_MRD   = 10'b0000010000,
		S_MCMP  = 10'b0000100000,
		S_ARD   = 10'b0001000000,
		S_ACMP  = 10'b0010000000,
		S_CMD   = 10'b0100000000,
		S_WAIT  = 10'b1000000000
	} state_t;

	state_t      state_q;
	logic [15:0] guard_q;
	logic [1:0]  mode_q, phase_q;
	logic        mark_q, pet_q;
	logic [16:0] elapsed_q;
	logic [CW-1:0] count_q;
	logic [7:0]  byte_q;
	logic        act_q, acc_q;
	logic [7:0]  mem [LINE_DEPTH];
	logic [7:0]  rd_q;
	logic [AW-1:0] raddr;
	logic [2:0]  word_q;
	logic [3:0]  ci_q;
	logic        wok_q;
	logic [CW-1:0] pos_q, start_q;
	logic        skip_q;
	logic [3:0]  code_q;
	result_t     res_q;
	logic        ov_q;
	logic        out_load;
	logic [1:0]  nx_mode, nx_phase;
	logic        nx_mark, nx_zero, esc_done, local_h, wr_en;
	logic [CW-1:0] base;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign kind = res_q.kind;
	assign out_byte = res_q.out_byte;
	assign command_code = res_q.command_code;
	assign applied = res_q.applied;
	assign arg_start = res_q.arg_start;
	assign arg_split = res_q.arg_split;
	assign line_length = res_q.line_length;
	assign petscii_mode = res_q.petscii_mode;
	assign last = res_q.last;

	assign out_load = (state_q == S_ECHO || state_q == S_LF || state_q == S_CMD)
		&& (!ov_q || !out_stall);

	logic paused;
	assign paused = mark_q && (elapsed_q > {1'b0, guard_q});

	// escape machine and line store update for the byte held in byte_q
	always_comb begin
		nx_mode = mode_q;
		nx_phase = phase_q;
		nx_mark = mark_q;
		nx_zero = 1'b0;
		esc_done = 1'b0;
		if (mode_q != MODE_USER) begin
			if (acc_q) begin
				nx_mode = MODE_ONLINE;
				case ((mode_q == MODE_ONLINE) ? phase_q : 2'd0) inside
					2'd0: begin
						nx_phase = 2'd0;
						if (paused) begin
							nx_mark = 1'b0;
							nx_phase = 2'd1;
						end
					end
					[2'd1:2'd2]: begin
						if (paused) begin
							nx_mark = 1'b0;
							nx_phase = 2'd1;
						end else if (byte_q == CH_PLUS) begin
							nx_mark = 1'b1;
							nx_zero = 1'b1;
							nx_phase = phase_q + 2'd1;
						end
					end
					default: begin
						if (!mark_q || elapsed_q > {1'b0, guard_q}) begin
							nx_mark = 1'b0;
							nx_phase = 2'd0;
							nx_mode = MODE_USER;
							esc_done = 1'b1;
						end
					end
				endcase
			end else
				nx_mode = MODE_OFFLINE;
		end
		local_h = (nx_mode != MODE_ONLINE);
		// a completed escape empties the line before this byte is stored
		base = esc_done ? '0 : count_q;
		wr_en = local_h && byte_q != CH_CR && byte_q != CH_LF && byte_q != 8'h00
			&& base < CW'(LINE_DEPTH - 1);
	end

	function automatic result_t echo_res(input logic [7:0] b, input logic p,
			input logic l);
		result_t r;
		r = '0;
		r.out_byte = b;
		r.petscii_mode = p;
		r.last = l;
		return r;
	endfunction

	// read address multiplexed between matcher and argument scan
	always_comb begin
		if (state_q == S_MRD)
			raddr = AW'(ci_q);
		else
			raddr = pos_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (state_q == S_DEC && !act_q && wr_en)
			mem[base[AW-1:0]] <= byte_q;
	end

	// argument separator for the matched command: comma for ssid, colon otherwise
	logic [7:0] sep;
	assign sep = (code_q == CMD_SSID) ? CH_COMMA : CH_COLON;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			guard_q <= GUARD_RESET;
			mode_q <= MODE_OFFLINE;
			phase_q <= 2'd0;
			mark_q <= 1'b0;
			pet_q <= 1'b0;
			elapsed_q <= '0;
			count_q <= '0;
			ov_q <= 1'b0;
			byte_q <= '0;
			act_q <= 1'b0;
			acc_q <= 1'b0;
			word_q <= '0;
			ci_q <= '0;
			wok_q <= 1'b0;
			pos_q <= '0;
			start_q <= '0;
			skip_q <= 1'b0;
			code_q <= '0;
			res_q <= '0;
		end else begin
			if (out_load)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid)
						guard_q <= cfg_data;
					if (in_valid) begin
						byte_q <= data_byte;
						act_q <= action;
						acc_q <= link_accepts;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (act_q) begin
						if (mark_q && elapsed_q < ELAPSED_MAX)
							elapsed_q <= elapsed_q + 17'd1;
						state_q <= S_IDLE;
					end else begin
						mode_q <= nx_mode;
						phase_q <= nx_phase;
						if (local_h && byte_q != CH_LF) begin
							mark_q <= 1'b1;
							elapsed_q <= '0;
							state_q <= S_ECHO;
						end else begin
							mark_q <= nx_mark;
							if (nx_zero)
								elapsed_q <= '0;
							state_q <= S_IDLE;
						end
						if (local_h)
							count_q <= wr_en ? base + CW'(1) : base;
					end
				end
				S_ECHO: if (!ov_q || !out_stall) begin
					res_q <= echo_res(byte_q, pet_q, byte_q != CH_CR);
					state_q <= (byte_q == CH_CR) ? S_LF : S_IDLE;
				end
				S_LF: if (!ov_q || !out_stall) begin
					res_q <= echo_res(CH_LF, pet_q, 1'b0);
					word_q <= '0;
					ci_q <= '0;
					wok_q <= 1'b1;
					state_q <= S_MRD;
				end
				S_MRD: state_q <= S_MCMP;
				S_MCMP: begin : mc
					logic ok;
					ok = wok_q && (fold(rd_q) == word_char(word_q, ci_q));
					if (ci_q + 4'd1 < word_len(word_q) && ok) begin
						wok_q <= 1'b1;
						ci_q <= ci_q + 4'd1;
						state_q <= S_MRD;
					end else begin
						if (ok && count_q >= CW'(word_len(word_q))
								&& (word_q > 3'd1 || count_q == CW'(6))) begin
							code_q <= {1'b0, word_q};
							if (word_q == 3'd2 || word_q == 3'd3) begin
								pos_q <= CW'(word_len(word_q));
								skip_q <= 1'b1;
								state_q <= S_ARD;
							end else begin
								start_q <= '0;
								pos_q <= '0;
								state_q <= S_CMD;
							end
						end else if (word_q == 3'd7) begin
							code_q <= CMD_UNKNOWN;
							start_q <= '0;
							pos_q <= '0;
							state_q <= S_CMD;
						end else begin
							word_q <= word_q + 3'd1;
							ci_q <= '0;
							wok_q <= 1'b1;
							state_q <= S_MRD;
						end
					end
				end
				S_ARD: begin
					if (pos_q >= count_q) begin
						if (skip_q) start_q <= pos_q;
						state_q <= S_CMD;
					end else
						state_q <= S_ACMP;
				end
				S_ACMP: begin
					if (skip_q) begin
						if (rd_q == CH_SPACE) pos_q <= pos_q + CW'(1);
						else begin
							skip_q <= 1'b0;
							start_q <= pos_q;
						end
						state_q <= S_ARD;
					end else if (rd_q == sep)
						state_q <= S_CMD;
					else begin
						pos_q <= pos_q + CW'(1);
						state_q <= S_ARD;
					end
				end
				S_CMD: if (!ov_q || !out_stall) begin : cm
					logic np;
					logic ap;
					result_t r;
					np = pet_q;
					ap = 1'b0;
					if (code_q == CMD_PETSCII) np = 1'b1;
					if (code_q == CMD_ASCII) np = 1'b0;
					if (code_q == CMD_ONLINE && mode_q == MODE_USER) begin
						ap = 1'b1;
						mode_q <= MODE_ONLINE;
					end
					pet_q <= np;
					r = '0;
					r.kind = 1'b1;
					r.command_code = code_q;
					r.applied = ap;
					r.arg_start = 6'(start_q);
					r.arg_split = 6'(pos_q);
					r.line_length = 6'(count_q);
					r.petscii_mode = np;
					r.last = 1'b1;
					res_q <= r;
					count_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/atcl_checker.sv
// Port-level checker for the AT command front end, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module atcl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic kind,
	input logic last,
	input logic [3:0] command_code,
	input logic cfg_ready
);
	`CHK_IMPLY(a_cmd_last, clk, arst_n, out_valid && kind, last, "command result not last")
	`CHK_IMPLY(a_code_range, clk, arst_n, out_valid && kind, command_code <= 4'd8, "bad code")
	`CHK_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "accepted while busy")
	`CHK_IMPLY(a_cfg_idle, clk, arst_n, cfg_ready, !in_stall, "config while busy")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(last) && $stable(command_code), "stalled result changed")
endmodule

bind at_command_line_with_escape_guard atcl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .kind(kind), .last(last),
	.command_code(command_code), .cfg_ready(cfg_ready));

// File: sim/at_command_line_with_escape_guard_chk.sv
// Checker: predicts echo and command results from accepted items and compares them
`timescale 1ns / 1ps
module at_command_line_with_escape_guard_chk
	import atcl_pkg::*;
#(
	parameter int LINE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        link_accepts,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        kind,
	input  logic [7:0]  out_byte,
	input  logic [3:0]  command_code,
	input  logic        applied,
	input  logic [5:0]  arg_start,
	input  logic [5:0]  arg_split,
	input  logic [5:0]  line_length,
	input  logic        petscii_mode,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output int          commands_seen
);
	result_t    echo_q[$];
	logic [15:0] guard;
	logic [1:0]  mode;
	logic [1:0]  phase;
	logic        mark;
	logic [16:0] elapsed;
	logic [7:0]  line_buf [LINE_DEPTH];
	int          line_len;
	logic        pet;

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic bit starts_with(input string w);
		if (line_len < w.len())
			return 0;
		for (int i = 0; i < w.len(); i++)
			if (lower(line_buf[i]) != w[i])
				return 0;
		return 1;
	endfunction

	function automatic int scan_arg(input int from, input logic [7:0] sep, output int split);
		int s;
		s = from;
		while (s < line_len && line_buf[s] == CH_SPACE)
			s++;
		split = s;
		while (split < line_len && line_buf[split] != sep)
			split++;
		return s;
	endfunction

	function automatic bit pause_seen();
		return mark && elapsed > {1'b0, guard};
	endfunction

	function automatic result_t echo_of(input logic [7:0] b);
		result_t r;
		r = '0;
		r.out_byte = b;
		r.petscii_mode = pet;
		return r;
	endfunction

	function automatic result_t line_result();
		result_t r;
		int st, sp;
		r = '0;
		r.kind = 1'b1;
		st = 0;
		sp = 0;
		if (line_len == 6 && starts_with("athelp"))
			r.command_code = CMD_HELP;
		else if (line_len == 6 && starts_with("atscan"))
			r.command_code = CMD_SCAN;
		else if (starts_with("atssid")) begin
			r.command_code = CMD_SSID;
			st = scan_arg(6, CH_COMMA, sp);
		end else if (starts_with("atd")) begin
			r.command_code = CMD_DIAL;
			st = scan_arg(3, CH_COLON, sp);
		end else if (starts_with("ato")) begin
			r.command_code = CMD_ONLINE;
			if (mode == MODE_USER) begin
				mode = MODE_ONLINE;
				r.applied = 1'b1;
			end
		end else if (starts_with("atpetscii")) begin
			r.command_code = CMD_PETSCII;
			pet = 1'b1;
		end else if (starts_with("atascii")) begin
			r.command_code = CMD_ASCII;
			pet = 1'b0;
		end else if (starts_with("ath"))
			r.command_code = CMD_HANGUP;
		else
			r.command_code = CMD_UNKNOWN;
		r.arg_start = st[5:0];
		r.arg_split = sp[5:0];
		r.line_length = line_len[5:0];
		r.petscii_mode = pet;
		return r;
	endfunction

	task automatic take_item(input logic act, input logic [7:0] b, input logic acc);
		result_t burst[$];
		if (act) begin
			if (mark && elapsed != ELAPSED_MAX)
				elapsed++;
			return;
		end
		if (mode != MODE_USER) begin
			if (acc) begin
				if (mode != MODE_ONLINE) begin
					mode = MODE_ONLINE;
					phase = 2'd0;
				end
				case (phase)
					2'd0: begin
						if (pause_seen()) begin
							mark = 1'b0;
							phase = 2'd1;
						end
					end
					2'd1, 2'd2: begin
						if (pause_seen()) begin
							mark = 1'b0;
							phase = 2'd1;
						end else if (b == CH_PLUS) begin
							mark = 1'b1;
							elapsed = '0;
							phase++;
						end
					end
					default: begin
						// escape completes on a trailing pause or with no mark at all
						if (!mark || elapsed > {1'b0, guard}) begin
							mark = 1'b0;
							phase = 2'd0;
							mode = MODE_USER;
							line_len = 0;
						end
					end
				endcase
				if (mode == MODE_ONLINE)
					return;
			end else
				mode = MODE_OFFLINE;
		end
		if (b != CH_LF) begin
			mark = 1'b1;
			elapsed = '0;
			burst.push_back(echo_of(b));
			if (b == CH_CR)
				burst.push_back(echo_of(CH_LF));
		end
		if (b == CH_CR) begin
			burst.push_back(line_result());
			line_len = 0;
		end else if (b != CH_LF && b != 8'h00 && line_len < LINE_DEPTH - 1) begin
			line_buf[line_len] = b;
			line_len++;
		end
		if (burst.size() > 0) begin
			burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i])
				echo_q.push_back(burst[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			echo_q.delete();
			pending = 0;
			guard <= GUARD_RESET;
			mode = MODE_OFFLINE;
			phase = 2'd0;
			mark = 1'b0;
			elapsed = '0;
			line_len = 0;
			pet = 1'b0;
			fail_count <= 0;
			results_seen <= 0;
			commands_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{kind, out_byte, command_code, applied, arg_start, arg_split,
					line_length, petscii_mode, last};
				results_seen <= results_seen + 1;
				if (kind)
					commands_seen <= commands_seen + 1;
				if (echo_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("mismatch: unexpected result %p", got);
				end else begin
					want = echo_q.pop_front();
					if (got !== want) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected %p, got %p", want, got);
					end
				end
			end
			if (in_valid && !in_stall)
				take_item(action, data_byte, link_accepts);
			if (cfg_valid && cfg_ready)
				guard <= cfg_data;
			pending = echo_q.size();
		end
	end
endmodule

// File: sim/at_command_line_with_escape_guard_tb.sv
// Testbench top: stimulus for the AT front end, idling phases and verdict
`timescale 1ns / 1ps
module at_command_line_with_escape_guard_tb;
	import atcl_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;
	localparam int NUM_RANDOM = 240;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        link_accepts = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  out_byte;
	logic [3:0]  command_code;
	logic        applied;
	logic [5:0]  arg_start;
	logic [5:0]  arg_split;
	logic [5:0]  line_length;
	logic        petscii_mode;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	int          fail_count, pending, results_seen, commands_seen;
	int          idle_pct = 0, stall_pct = 0;
	int          escapes_tried = 0;
	int          sent = 0;
	logic [15:0] guard_now = GUARD_RESET;
	longint      cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	at_command_line_with_escape_guard u_top (.*);

	at_command_line_with_escape_guard_chk u_chk (.*);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("at_command_line_with_escape_guard test failed");
			$finish;
		end
	end

	task automatic send(input logic act, input logic [7:0] b, input logic acc);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		link_accepts <= acc;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic send_text(input string s, input logic acc);
		for (int i = 0; i < s.len(); i++)
			send(1'b0, s[i], acc);
	endtask

	task automatic ticks(input int n);
		for (int i = 0; i < n; i++)
			send(1'b1, 8'($urandom), 1'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// a tick or online byte may still be in the block
		repeat (150) @(posedge clk);
	endtask

	task automatic write_guard(input logic [15:0] g);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		guard_now = g;
	endtask

	// pause, a byte, ++, pause, a byte; a broken run spoils one step
	task automatic escape(input bit broken);
		int spoil;
		spoil = broken ? $urandom_range(3) : 4;
		escapes_tried++;
		send(1'b0, "x", 1'b0);
		ticks(guard_now + 1 + $urandom_range(2) - (spoil == 0 ? 2 : 0));
		send(1'b0, 8'($urandom), 1'b1);
		send(1'b0, (spoil == 1) ? "-" : CH_PLUS, 1'b1);
		send(1'b0, CH_PLUS, 1'b1);
		ticks(guard_now + 1 + $urandom_range(2) - (spoil == 2 ? 2 : 0));
		send(1'b0, 8'($urandom), (spoil == 3) ? 1'b0 : 1'b1);
	endtask

	function automatic string mixed_case(input string s);
		string t;
		t = s;
		for (int i = 0; i < t.len(); i++)
			if (t[i] >= "a" && t[i] <= "z" && $urandom_range(1))
				t[i] = t[i] - 8'd32;
		return t;
	endfunction

	function automatic string random_line();
		string words [9] = '{"athelp", "atscan", "atssid", "atd", "ato",
			"atpetscii", "atascii", "ath", "az"};
		string s;
		int n;
		s = mixed_case(words[$urandom_range(8)]);
		n = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(8);
		for (int i = 0; i < n; i++)
			case ($urandom_range(5))
				0: s = {s, " "};
				1: s = {s, ","};
				2: s = {s, ":"};
				default: s = {s, string'(byte'($urandom_range(32, 126)))};
			endcase
		return {s, "\r"};
	endfunction

	// runs until about n more items have been sent
	task automatic random_phase(input int n);
		int stop;
		stop = sent + n;
		while (sent < stop) begin
			case ($urandom_range(9)) inside
				[0:3]: send_text(random_line(), ($urandom_range(3) == 0) ? 1'b0 :
					1'($urandom_range(1)));
				[4:5]: begin
					escape($urandom_range(3) == 0);
					send_text(mixed_case("ato\r"), 1'b0);
				end
				6: send(1'b0, 8'($urandom), 1'b1);
				default: send(1'($urandom_range(1)), 8'($urandom),
					1'($urandom_range(1)));
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every command, extremes of bytes, a one-byte line and an overlong line
		send_text("athelp\r", 1'b0);
		send_text("ATSCAN\r", 1'b0);
		send_text("AtSsid  net,pw\r", 1'b0);
		send_text("atd host:80\r", 1'b0);
		send_text("ato\r", 1'b0);
		send_text("atpetscii\r", 1'b0);
		send_text("atascii\r", 1'b0);
		send_text("ath\r", 1'b0);
		send(1'b0, 8'h00, 1'b0);
		send(1'b0, 8'hFF, 1'b0);
		send(1'b0, CH_LF, 1'b0);
		send(1'b0, CH_CR, 1'b0);
		for (int i = 0; i < 70; i++)
			send(1'b0, "a", 1'b0);
		send(1'b0, CH_CR, 1'b0);

		write_guard(16'd1);
		escape(0);
		send_text("ato\r", 1'b0);
		send(1'b0, "q", 1'b1);

		for (int p = 0; p < 4; p++) begin
			write_guard(p == 0 ? 16'd1 : 16'($urandom_range(1, 4)));
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			random_phase(NUM_RANDOM / 8);
			// hold off until every result is back
			in_valid <= 1'b0;
			@(posedge clk);
			while (pending != 0)
				@(posedge clk);
			random_phase(NUM_RANDOM / 8);
		end

		// widest guard: short gaps never count as a pause
		idle_pct = 0;
		stall_pct = 0;
		write_guard(16'hFFFF);
		send(1'b0, "x", 1'b0);
		ticks(10);
		send(1'b0, "y", 1'b1);
		send_text("++", 1'b1);
		ticks(10);
		send(1'b0, "z", 1'b1);
		send_text("ath\r", 1'b0);
		write_guard(16'd3);
		random_phase(20);

		drain();
		$display("covered %0d results (%0d command lines), %0d escape attempts",
			results_seen, commands_seen, escapes_tried);
		$display("over four idling phases and guard settings from 1 to 65535");
		if (fail_count == 0)
			$display("at_command_line_with_escape_guard test passed");
		else
			$display("at_command_line_with_escape_guard test failed");
		$finish;
	end
endmodule

// File: at_command_line_with_escape_guard.f
+incdir+sv
sv/atcl_pkg.sv
sv/at_command_line_with_escape_guard.sv
sv/atcl_checker.sv
sim/at_command_line_with_escape_guard_chk.sv
sim/at_command_line_with_escape_guard_tb.sv
